### design/tic_pkg.sv
`default_nettype none
package tic_pkg;

  // Sizing of the waypoint counters
  localparam int MAX_POINTS = 64;
  localparam int PC_W       = $clog2(MAX_POINTS + 1);

  // Fixed-point constants (Q16.16 inputs, Q32.16 costs)
  localparam logic [47:0] SAT48              = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] INFEASIBLE_PENALTY = 48'd65536000;
  localparam logic [47:0] ONE_Q              = 48'd65536;
  localparam logic [47:0] CAUTION_Q          = 48'd52429;
  localparam logic signed [19:0] PI_Q        = 20'sd205887;
  localparam logic signed [19:0] TWO_PI_Q    = 20'sd411775;

  // Iterative unit sizes
  localparam int DIV_W  = 48;
  localparam int DSR_W  = 32;
  localparam int RAD_W  = 66;
  localparam int ROOT_W = 36;

  typedef enum logic [2:0] {
    REG_GOAL_X, REG_GOAL_Y, REG_GOAL_Z, REG_INTEGRITY_WEIGHT,
    REG_MISSION_WEIGHT, REG_SMOOTH_WEIGHT, REG_TURN_WEIGHT, REG_ALIGN_WEIGHT
  } reg_idx_t;

  typedef enum logic [1:0] {DIV_RATIO, DIV_EFFORT, DIV_ALIGN} div_sel_t;
  typedef enum logic [1:0] {MUL_SQ, MUL_HINGE, MUL_WLO, MUL_WHI} mul_sel_t;
  typedef enum logic [1:0] {NRM_PREV, NRM_FUT, NRM_GOAL} nrm_sel_t;
  typedef enum logic [2:0] {
    TERM_INTEG, TERM_GOAL, TERM_EFFORT, TERM_TURN, TERM_ALIGN
  } term_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] protection_level;
    logic signed [31:0] alert_limit;
    logic signed [18:0] heading;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic               future_valid;
    logic signed [18:0] future_heading;
    logic signed [31:0] future_vel_x;
    logic signed [31:0] future_vel_y;
    logic signed [31:0] future_vel_z;
  } item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    mul_sel_t mul_sel;
    logic [1:0] sq_idx;
    logic     acc_clr;
    logic     acc_add;
    logic     sqrt_start;
    nrm_sel_t nrm_sel;
    logic     breach_set;
    logic     hinge_upd;
    logic     turn_upd;
    logic     effort_upd;
    logic     align_upd;
    logic     commit;
    logic     jclr;
    logic     jgoal_upd;
    logic     jeff_upd;
    logic     jal_upd;
    term_t    term;
    logic     tot_clr;
    logic     tot_add;
    logic     pen_add;
    logic     out_load;
    logic     acc_reset;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic op;
    logic full;
    logic al_nonpos;
    logic pl_pos;
    logic pc_nz;
    logic pc_ge2;
    logic mc_nz;
    logic fut_valid;
    logic div_done;
    logic sqrt_done;
  } sts_t;

  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? SAT48 : s[47:0];
  endfunction

  // Magnitude of a heading difference wrapped into [-pi, pi]
  function automatic logic [17:0] wrap_abs(input logic signed [18:0] a,
                                           input logic signed [18:0] b);
    logic signed [19:0] d;
    logic signed [19:0] w;
    d = {a[18], a} - {b[18], b};
    if (d > PI_Q)       w = d - TWO_PI_Q;
    else if (d < -PI_Q) w = d + TWO_PI_Q;
    else                w = d;
    w = w[19] ? -w : w;
    return w[17:0];
  endfunction

endpackage
`default_nettype wire

### design/trajectory_integrity_cost_unit.sv
`default_nettype none
// Trajectory integrity cost unit.
// Waypoint items enter on the in_ stream (in_tuser[0] = 0), an end item
// (in_tuser[0] = 1) carrying the final position closes the trajectory and
// produces one result transfer on the out_ stream; waypoints give no result.
// Weights and the goal are written on the cfg_ port while the unit is idle.
// One item is worked on at a time; in_tready is high only between items.
// A waypoint that is ignored does no arithmetic; otherwise it runs the
// ratio division and each velocity norm that applies. An end item runs
// the goal norm and each mean division that applies. The work is done by
// the 48-step divider and the 36-step square-root unit.
// The result sits in an output register: a new item is accepted while it
// waits, and only the next end item stalls until out_tready takes it.
// Synchronous reset clears the accumulators, loads default weights and
// drops out_tvalid.
module trajectory_integrity_cost_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // protection_level, alert_limit, heading, vec_x, vec_y, vec_z,
  // future_heading, future_vel_x, future_vel_y, future_vel_z, zero pad
  input  wire logic [295:0] in_tdata,
  // op, future_valid
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // total_cost, integrity_cost, goal_cost, effort_cost
  output logic [191:0]      out_tdata,
  // infeasible
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);
  tic_pkg::item_t item;
  tic_pkg::cmd_t  cmd;
  tic_pkg::sts_t  sts;
  logic [47:0]    total_cost, integrity_cost, goal_cost, effort_cost;
  logic           infeasible;

  // Unpack the input transfer
  always_comb begin
    item.op               = in_tuser[0];
    item.protection_level = in_tdata[31:0];
    item.alert_limit      = in_tdata[63:32];
    item.heading          = in_tdata[82:64];
    item.vec_x            = in_tdata[114:83];
    item.vec_y            = in_tdata[146:115];
    item.vec_z            = in_tdata[178:147];
    item.future_valid     = in_tuser[1];
    item.future_heading   = in_tdata[197:179];
    item.future_vel_x     = in_tdata[229:198];
    item.future_vel_y     = in_tdata[261:230];
    item.future_vel_z     = in_tdata[293:262];
  end

  tic_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tic_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .item           (item),
    .cmd            (cmd),
    .sts            (sts),
    .total_cost     (total_cost),
    .integrity_cost (integrity_cost),
    .goal_cost      (goal_cost),
    .effort_cost    (effort_cost),
    .infeasible     (infeasible)
  );

  assign out_tdata = {effort_cost, goal_cost, integrity_cost, total_cost};
  assign out_tuser = infeasible;
endmodule
`default_nettype wire

### design/tic_div.sv
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle
module tic_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [tic_pkg::DIV_W-1:0]  dividend,
  input  wire logic [tic_pkg::DSR_W-1:0]  divisor,
  output logic                            done,
  output logic [tic_pkg::DIV_W-1:0]       quotient
);
  localparam int CNT_W = $clog2(tic_pkg::DIV_W);

  logic                      busy_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [tic_pkg::DIV_W-1:0] q_r;
  logic [tic_pkg::DSR_W-1:0] rem_r;
  logic [tic_pkg::DSR_W-1:0] dsr_r;
  logic [tic_pkg::DSR_W:0]   rem_sh;
  logic [tic_pkg::DSR_W:0]   trial;

  assign rem_sh = {rem_r, q_r[tic_pkg::DIV_W-1]};
  assign trial  = rem_sh - {1'b0, dsr_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(tic_pkg::DIV_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  // Shift-subtract step
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      if (!trial[tic_pkg::DSR_W]) begin
        rem_r <= trial[tic_pkg::DSR_W-1:0];
        q_r   <= {q_r[tic_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[tic_pkg::DSR_W-1:0];
        q_r   <= {q_r[tic_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

### design/tic_sqrt.sv
`default_nettype none
// Digit-by-digit floor square root, one root bit per cycle
module tic_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tic_pkg::RAD_W-1:0]   radicand,
  output logic                             done,
  output logic [tic_pkg::ROOT_W-1:0]       root
);
  localparam int PAD_W = 2 * tic_pkg::ROOT_W;
  localparam int REM_W = tic_pkg::ROOT_W + 2;
  localparam int CNT_W = $clog2(tic_pkg::ROOT_W);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [PAD_W-1:0]            rad_r;
  logic [REM_W-1:0]            rem_r;
  logic [tic_pkg::ROOT_W-1:0]  root_r;
  logic [REM_W+1:0]            rem_sh;
  logic [REM_W+1:0]            trial;
  logic [REM_W+1:0]            diff;

  assign rem_sh = {rem_r, rad_r[PAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign diff   = rem_sh - trial;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(tic_pkg::ROOT_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  // Trial subtract per root bit
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= {{(PAD_W - tic_pkg::RAD_W){1'b0}}, radicand};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[PAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= diff[REM_W-1:0];
        root_r <= {root_r[tic_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[REM_W-1:0];
        root_r <= {root_r[tic_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

### design/tic_dp.sv
`default_nettype none
module tic_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_addr,
  input  wire logic [31:0]    cfg_wdata,
  input  wire tic_pkg::item_t item,
  input  wire tic_pkg::cmd_t  cmd,
  output tic_pkg::sts_t       sts,
  output logic [47:0]         total_cost,
  output logic [47:0]         integrity_cost,
  output logic [47:0]         goal_cost,
  output logic [47:0]         effort_cost,
  output logic                infeasible
);
  localparam int PC_W = tic_pkg::PC_W;

  // Configuration registers
  logic signed [31:0] goal_x_r, goal_y_r, goal_z_r;
  logic [30:0] w_integ_r, w_mission_r, w_smooth_r, w_turn_r, w_align_r;

  // Captured item
  tic_pkg::item_t item_r;

  // Accumulated trajectory state
  logic [47:0]        hinge_sum_r, turn_sum_r, effort_sum_r, align_sum_r;
  logic [PC_W-1:0]    pc_r, mc_r;
  logic               breach_r;
  logic signed [18:0] prev_hd_r;
  logic signed [31:0] prev_vx_r, prev_vy_r, prev_vz_r;

  // Shared arithmetic
  logic signed [31:0] va, vb;
  logic signed [32:0] dsel;
  logic [31:0]        dabs;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_r, wlo_r;
  logic [65:0]        sq_acc_r;
  logic [47:0]        div_dvd;
  logic [31:0]        div_dsr;
  logic               div_done, sqrt_done;
  logic [47:0]        quot;
  logic [35:0]        root;

  // Hinge and weighting
  logic               ge_one, gt_c;
  logic [47:0]        h;
  logic [47:0]        hterm;
  logic [30:0]        wsel;
  logic [47:0]        jsel;
  logic [79:0]        wprod;
  logic [47:0]        wv;
  logic [17:0]        fwrap;

  // End-of-run terms and outputs
  logic [35:0]        jgoal_r;
  logic [47:0]        jeff_r, jal_r;
  logic [47:0]        tot_w_r, ci_w_r, cg_w_r, ce_w_r;
  logic [47:0]        o_tot_r, o_ci_r, o_cg_r, o_ce_r;
  logic               o_inf_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      goal_z_r    <= '0;
      w_integ_r   <= 31'd65536;
      w_mission_r <= 31'd65536;
      w_smooth_r  <= 31'd65536;
      w_turn_r    <= 31'd65536;
      w_align_r   <= '0;
    end else if (cfg_we) begin
      unique case (tic_pkg::reg_idx_t'(cfg_addr))
        tic_pkg::REG_GOAL_X:           goal_x_r    <= cfg_wdata;
        tic_pkg::REG_GOAL_Y:           goal_y_r    <= cfg_wdata;
        tic_pkg::REG_GOAL_Z:           goal_z_r    <= cfg_wdata;
        tic_pkg::REG_INTEGRITY_WEIGHT: w_integ_r   <= cfg_wdata[30:0];
        tic_pkg::REG_MISSION_WEIGHT:   w_mission_r <= cfg_wdata[30:0];
        tic_pkg::REG_SMOOTH_WEIGHT:    w_smooth_r  <= cfg_wdata[30:0];
        tic_pkg::REG_TURN_WEIGHT:      w_turn_r    <= cfg_wdata[30:0];
        tic_pkg::REG_ALIGN_WEIGHT:     w_align_r   <= cfg_wdata[30:0];
      endcase
    end
  end

  // Item capture on input transfer
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= item;
  end

  // Vector difference for the norm currently in progress
  always_comb begin
    unique case (cmd.sq_idx)
      2'd0:    va = item_r.vec_x;
      2'd1:    va = item_r.vec_y;
      2'd2:    va = item_r.vec_z;
      default: va = item_r.vec_x;
    endcase
    unique case (cmd.nrm_sel)
      tic_pkg::NRM_PREV: begin
        unique case (cmd.sq_idx)
          2'd1:    vb = prev_vy_r;
          2'd2:    vb = prev_vz_r;
          default: vb = prev_vx_r;
        endcase
      end
      tic_pkg::NRM_FUT: begin
        unique case (cmd.sq_idx)
          2'd1:    vb = item_r.future_vel_y;
          2'd2:    vb = item_r.future_vel_z;
          default: vb = item_r.future_vel_x;
        endcase
      end
      tic_pkg::NRM_GOAL: begin
        unique case (cmd.sq_idx)
          2'd1:    vb = goal_y_r;
          2'd2:    vb = goal_z_r;
          default: vb = goal_x_r;
        endcase
      end
      default: vb = prev_vx_r;
    endcase
    dsel = {va[31], va} - {vb[31], vb};
    dabs = dsel[32] ? 32'(-dsel) : dsel[31:0];
  end

  // Hinge base from the ratio quotient
  assign ge_one = quot >= tic_pkg::ONE_Q;
  assign gt_c   = quot > tic_pkg::CAUTION_Q;
  assign h      = ge_one ? quot - tic_pkg::ONE_Q : quot - tic_pkg::CAUTION_Q;
  assign hterm  = (|h[47:32]) ? tic_pkg::SAT48 : mul_r[63:16];

  // Weight and cost selection for the weighting pass
  always_comb begin
    unique case (cmd.term)
      tic_pkg::TERM_INTEG:  begin wsel = w_integ_r;   jsel = hinge_sum_r;         end
      tic_pkg::TERM_GOAL:   begin wsel = w_mission_r; jsel = {12'b0, jgoal_r};    end
      tic_pkg::TERM_EFFORT: begin wsel = w_smooth_r;  jsel = jeff_r;              end
      tic_pkg::TERM_TURN:   begin wsel = w_turn_r;    jsel = turn_sum_r;          end
      tic_pkg::TERM_ALIGN:  begin wsel = w_align_r;   jsel = jal_r;               end
      default:              begin wsel = w_integ_r;   jsel = hinge_sum_r;         end
    endcase
  end

  // Multiplier operand mux
  always_comb begin
    unique case (cmd.mul_sel)
      tic_pkg::MUL_SQ:    begin mul_a = dabs;         mul_b = dabs;                  end
      tic_pkg::MUL_HINGE: begin mul_a = h[31:0];      mul_b = h[31:0];               end
      tic_pkg::MUL_WLO:   begin mul_a = {1'b0, wsel}; mul_b = {8'b0, jsel[23:0]};    end
      tic_pkg::MUL_WHI:   begin mul_a = {1'b0, wsel}; mul_b = {8'b0, jsel[47:24]};   end
      default:            begin mul_a = dabs;         mul_b = dabs;                  end
    endcase
  end

  // Shared 32x32 multiplier; the low partial product is delayed through wlo_r
  always_ff @(posedge clk) begin
    mul_r <= {32'b0, mul_a} * {32'b0, mul_b};
    wlo_r <= mul_r;
  end

  assign wprod = {1'b0, mul_r[54:0], 24'b0} + {16'b0, wlo_r};
  assign wv    = (|wprod[79:64]) ? tic_pkg::SAT48 : wprod[63:16];

  // Sum of squares
  always_ff @(posedge clk) begin
    if (cmd.acc_clr)      sq_acc_r <= '0;
    else if (cmd.acc_add) sq_acc_r <= sq_acc_r + {2'b0, mul_r};
  end

  // Divider operands
  always_comb begin
    unique case (cmd.div_sel)
      tic_pkg::DIV_RATIO: begin
        div_dvd = {1'b0, item_r.protection_level[30:0], 16'b0};
        div_dsr = {1'b0, item_r.alert_limit[30:0]};
      end
      tic_pkg::DIV_EFFORT: begin
        div_dvd = effort_sum_r;
        div_dsr = {{(32 - PC_W){1'b0}}, pc_r - PC_W'(1)};
      end
      tic_pkg::DIV_ALIGN: begin
        div_dvd = align_sum_r;
        div_dsr = {{(32 - PC_W){1'b0}}, mc_r};
      end
      default: begin
        div_dvd = effort_sum_r;
        div_dsr = {{(32 - PC_W){1'b0}}, mc_r};
      end
    endcase
  end

  tic_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (quot)
  );

  tic_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (sq_acc_r),
    .done     (sqrt_done),
    .root     (root)
  );

  assign fwrap = tic_pkg::wrap_abs(item_r.heading, item_r.future_heading);

  // Trajectory accumulators, cleared once the result is issued
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.acc_reset) begin
      hinge_sum_r  <= '0;
      turn_sum_r   <= '0;
      effort_sum_r <= '0;
      align_sum_r  <= '0;
      pc_r         <= '0;
      mc_r         <= '0;
      breach_r     <= 1'b0;
      prev_hd_r    <= '0;
      prev_vx_r    <= '0;
      prev_vy_r    <= '0;
      prev_vz_r    <= '0;
    end else begin
      if (cmd.breach_set) breach_r <= 1'b1;
      if (cmd.hinge_upd && (ge_one || gt_c)) begin
        hinge_sum_r <= tic_pkg::sat_add(hinge_sum_r, hterm);
        if (ge_one) breach_r <= 1'b1;
      end
      if (cmd.turn_upd)
        turn_sum_r <= tic_pkg::sat_add(turn_sum_r,
                        {30'b0, tic_pkg::wrap_abs(item_r.heading, prev_hd_r)});
      if (cmd.effort_upd)
        effort_sum_r <= tic_pkg::sat_add(effort_sum_r, {12'b0, root});
      if (cmd.align_upd) begin
        align_sum_r <= tic_pkg::sat_add(align_sum_r,
                         tic_pkg::sat_add({12'b0, root}, {31'b0, fwrap[17:1]}));
        mc_r <= mc_r + PC_W'(1);
      end
      if (cmd.commit) begin
        prev_hd_r <= item_r.heading;
        prev_vx_r <= item_r.vec_x;
        prev_vy_r <= item_r.vec_y;
        prev_vz_r <= item_r.vec_z;
        pc_r      <= pc_r + PC_W'(1);
      end
    end
  end

  // End-of-run raw costs
  always_ff @(posedge clk) begin
    if (cmd.jclr) begin
      jgoal_r <= '0;
      jeff_r  <= '0;
      jal_r   <= '0;
    end else begin
      if (cmd.jgoal_upd) jgoal_r <= root;
      if (cmd.jeff_upd)  jeff_r  <= quot;
      if (cmd.jal_upd)   jal_r   <= quot;
    end
  end

  // Weighted cost build-up
  always_ff @(posedge clk) begin
    if (cmd.tot_clr) begin
      tot_w_r <= '0;
    end else if (cmd.tot_add) begin
      tot_w_r <= tic_pkg::sat_add(tot_w_r, wv);
      unique case (cmd.term)
        tic_pkg::TERM_INTEG:  ci_w_r <= wv;
        tic_pkg::TERM_GOAL:   cg_w_r <= wv;
        tic_pkg::TERM_EFFORT: ce_w_r <= wv;
        default: ;
      endcase
    end else if (cmd.pen_add && breach_r) begin
      tot_w_r <= tic_pkg::sat_add(tot_w_r, tic_pkg::INFEASIBLE_PENALTY);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_tot_r <= tot_w_r;
      o_ci_r  <= ci_w_r;
      o_cg_r  <= cg_w_r;
      o_ce_r  <= ce_w_r;
      o_inf_r <= breach_r;
    end
  end

  // Status
  always_comb begin
    sts.op        = item_r.op;
    sts.full      = pc_r >= PC_W'(tic_pkg::MAX_POINTS);
    sts.al_nonpos = item_r.alert_limit[31] || (item_r.alert_limit == '0);
    sts.pl_pos    = !item_r.protection_level[31] && (item_r.protection_level != '0);
    sts.pc_nz     = pc_r != '0;
    sts.pc_ge2    = pc_r >= PC_W'(2);
    sts.mc_nz     = mc_r != '0;
    sts.fut_valid = item_r.future_valid;
    sts.div_done  = div_done;
    sts.sqrt_done = sqrt_done;
  end

  assign total_cost     = o_tot_r;
  assign integrity_cost = o_ci_r;
  assign goal_cost      = o_cg_r;
  assign effort_cost    = o_ce_r;
  assign infeasible     = o_inf_r;
endmodule
`default_nettype wire

### design/tic_ctrl.sv
`default_nettype none
module tic_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire tic_pkg::sts_t sts,
  output tic_pkg::cmd_t      cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_DIVW, S_HMUL, S_HADD, S_TURN,
    S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_RT, S_RTW, S_FUT, S_UPD,
    S_EDIV, S_EDIVW, S_ADIV, S_ADIVW, S_WLO, S_WHI, S_WSUM, S_PEN, S_OUT
  } state_t;

  state_t            state_r;
  tic_pkg::nrm_sel_t nsel_r;
  tic_pkg::term_t    term_r;
  logic              out_valid_r;
  logic              out_free;
  logic              out_set;

  assign out_free = !out_valid_r || out_tready;
  assign out_set  = (state_r == S_OUT) && out_free;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nsel_r      <= tic_pkg::NRM_PREV;
      term_r      <= tic_pkg::TERM_INTEG;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_set || (out_valid_r && !out_tready);
      unique case (state_r)
        S_IDLE:  if (in_tvalid) state_r <= S_CHECK;
        S_CHECK: begin
          if (sts.op) begin
            if (sts.pc_nz) begin
              nsel_r  <= tic_pkg::NRM_GOAL;
              state_r <= S_SQ0;
            end else begin
              state_r <= S_EDIV;
            end
          end else if (sts.full)      state_r <= S_IDLE;
          else if (sts.al_nonpos)     state_r <= S_TURN;
          else if (sts.pl_pos)        state_r <= S_DIVW;
          else                        state_r <= S_TURN;
        end
        S_DIVW:  if (sts.div_done) state_r <= S_HMUL;
        S_HMUL:  state_r <= S_HADD;
        S_HADD:  state_r <= S_TURN;
        S_TURN: begin
          if (sts.pc_nz) begin
            nsel_r  <= tic_pkg::NRM_PREV;
            state_r <= S_SQ0;
          end else begin
            state_r <= S_FUT;
          end
        end
        S_SQ0:   state_r <= S_SQ1;
        S_SQ1:   state_r <= S_SQ2;
        S_SQ2:   state_r <= S_SQ3;
        S_SQ3:   state_r <= S_RT;
        S_RT:    state_r <= S_RTW;
        S_RTW: begin
          if (sts.sqrt_done) begin
            unique case (nsel_r)
              tic_pkg::NRM_PREV: state_r <= S_FUT;
              tic_pkg::NRM_FUT:  state_r <= S_UPD;
              tic_pkg::NRM_GOAL: state_r <= S_EDIV;
              default:           state_r <= S_FUT;
            endcase
          end
        end
        S_FUT: begin
          if (sts.fut_valid) begin
            nsel_r  <= tic_pkg::NRM_FUT;
            state_r <= S_SQ0;
          end else begin
            state_r <= S_UPD;
          end
        end
        S_UPD:   state_r <= S_IDLE;
        S_EDIV:  state_r <= sts.pc_ge2 ? S_EDIVW : S_ADIV;
        S_EDIVW: if (sts.div_done) state_r <= S_ADIV;
        S_ADIV: begin
          term_r  <= tic_pkg::TERM_INTEG;
          state_r <= sts.mc_nz ? S_ADIVW : S_WLO;
        end
        S_ADIVW: if (sts.div_done) state_r <= S_WLO;
        S_WLO:   state_r <= S_WHI;
        S_WHI:   state_r <= S_WSUM;
        S_WSUM: begin
          if (term_r == tic_pkg::TERM_ALIGN) begin
            state_r <= S_PEN;
          end else begin
            term_r  <= tic_pkg::term_t'(term_r + 3'd1);
            state_r <= S_WLO;
          end
        end
        S_PEN:   state_r <= S_OUT;
        S_OUT: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd         = '0;
    cmd.nrm_sel = nsel_r;
    cmd.term    = term_r;
    unique case (state_r)
      S_IDLE:  cmd.load = in_tvalid;
      S_CHECK: begin
        if (sts.op) begin
          cmd.jclr    = 1'b1;
          cmd.tot_clr = 1'b1;
        end else if (!sts.full) begin
          if (sts.al_nonpos) begin
            cmd.breach_set = 1'b1;
          end else if (sts.pl_pos) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = tic_pkg::DIV_RATIO;
          end
        end
      end
      S_HMUL:  cmd.mul_sel   = tic_pkg::MUL_HINGE;
      S_HADD:  cmd.hinge_upd = 1'b1;
      S_TURN:  cmd.turn_upd  = sts.pc_nz;
      S_SQ0: begin
        cmd.mul_sel = tic_pkg::MUL_SQ;
        cmd.sq_idx  = 2'd0;
        cmd.acc_clr = 1'b1;
      end
      S_SQ1: begin
        cmd.mul_sel = tic_pkg::MUL_SQ;
        cmd.sq_idx  = 2'd1;
        cmd.acc_add = 1'b1;
      end
      S_SQ2: begin
        cmd.mul_sel = tic_pkg::MUL_SQ;
        cmd.sq_idx  = 2'd2;
        cmd.acc_add = 1'b1;
      end
      S_SQ3:   cmd.acc_add    = 1'b1;
      S_RT:    cmd.sqrt_start = 1'b1;
      S_RTW: begin
        if (sts.sqrt_done) begin
          unique case (nsel_r)
            tic_pkg::NRM_PREV: cmd.effort_upd = 1'b1;
            tic_pkg::NRM_FUT:  cmd.align_upd  = 1'b1;
            tic_pkg::NRM_GOAL: cmd.jgoal_upd  = 1'b1;
            default: ;
          endcase
        end
      end
      S_UPD:   cmd.commit = 1'b1;
      S_EDIV: begin
        cmd.div_start = sts.pc_ge2;
        cmd.div_sel   = tic_pkg::DIV_EFFORT;
      end
      S_EDIVW: cmd.jeff_upd = sts.div_done;
      S_ADIV: begin
        cmd.div_start = sts.mc_nz;
        cmd.div_sel   = tic_pkg::DIV_ALIGN;
      end
      S_ADIVW: cmd.jal_upd = sts.div_done;
      S_WLO:   cmd.mul_sel = tic_pkg::MUL_WLO;
      S_WHI:   cmd.mul_sel = tic_pkg::MUL_WHI;
      S_WSUM:  cmd.tot_add = 1'b1;
      S_PEN:   cmd.pen_add = 1'b1;
      S_OUT: begin
        cmd.out_load  = out_free;
        cmd.acc_reset = out_free;
      end
      default: ;
    endcase
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
endmodule
`default_nettype wire

### design/tic_chk.sv
`default_nettype none
module tic_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [191:0] out_tdata,
  input wire logic [0:0]   out_tuser
);
  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Total never falls below the integrity, goal or effort cost
  a_total_dominates: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:0] >= out_tdata[95:48] &&
                   out_tdata[47:0] >= out_tdata[143:96] &&
                   out_tdata[47:0] >= out_tdata[191:144])
    else $error("total below a component cost");

  // An infeasible trajectory carries at least the penalty
  a_penalty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[47:0] >= tic_pkg::INFEASIBLE_PENALTY)
    else $error("infeasible result without penalty");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
endmodule

bind trajectory_integrity_cost_unit tic_chk u_chk (.*);
`default_nettype wire

### bench/tb_top.sv
`default_nettype none
module tb_top;
  import tic_pkg::*;

  typedef struct {
    logic [47:0] total;
    logic [47:0] integ;
    logic [47:0] goal;
    logic [47:0] effort;
    logic        infeasible;
  } cost_t;

  localparam int IDLE_GAP   = 200;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [295:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_we = 1'b0;
  reg_idx_t cfg_addr = REG_GOAL_X;
  logic [31:0] cfg_wdata = '0;

  item_t item_q[$];
  cost_t cost_q[$];
  int errors = 0;
  int idle_mode = 0;
  bit took = 0;
  int quiet_cycles = 0;

  // Scorer state and register copies
  logic [47:0] hinge_acc, turn_acc, effort_acc, align_acc;
  int n_match, n_pts;
  bit breached;
  logic signed [18:0] last_hd;
  longint last_v[3];
  longint goal_p[3];
  logic [30:0] w_int, w_mis, w_smo, w_turn, w_al;

  trajectory_integrity_cost_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [47:0] sat48(logic [127:0] s);
    return (s > {80'b0, SAT48}) ? SAT48 : s[47:0];
  endfunction

  function automatic longint mag(longint a);
    return (a < 0) ? -a : a;
  endfunction

  // Floor square root of a sum of three squares
  function automatic logic [47:0] vec_norm(longint a, longint b, longint c);
    logic [127:0] s, ua, ub, uc, t;
    logic [47:0] r;
    ua = mag(a);
    ub = mag(b);
    uc = mag(c);
    s = ua * ua + ub * ub + uc * uc;
    r = '0;
    for (int bit_i = 35; bit_i >= 0; bit_i--) begin
      t = {80'b0, r} | (128'd1 << bit_i);
      if (t * t <= s) r = t[47:0];
    end
    return r;
  endfunction

  function automatic logic [47:0] angle_mag(longint d);
    while (d > 205887) d -= 411775;
    while (d < -205887) d += 411775;
    return mag(d);
  endfunction

  function automatic logic [47:0] weigh(logic [30:0] w, logic [47:0] j);
    logic [127:0] pw, pj;
    pw = w;
    pj = j;
    return sat48((pw * pj) >> 16);
  endfunction

  function automatic logic [47:0] hinge_sq(longint h);
    logic [127:0] u;
    if (h >= 64'sd4294967296) return SAT48;
    u = h;
    return (u * u) >> 16;
  endfunction

  function automatic void clear_acc();
    hinge_acc = '0; turn_acc = '0; effort_acc = '0; align_acc = '0;
    n_match = 0; n_pts = 0; breached = 0; last_hd = '0;
    last_v[0] = 0; last_v[1] = 0; last_v[2] = 0;
  endfunction

  function automatic void apply_reg(reg_idx_t idx, logic [31:0] v);
    case (idx)
      REG_GOAL_X: goal_p[0] = longint'($signed(v));
      REG_GOAL_Y: goal_p[1] = longint'($signed(v));
      REG_GOAL_Z: goal_p[2] = longint'($signed(v));
      REG_INTEGRITY_WEIGHT: w_int = v[30:0];
      REG_MISSION_WEIGHT: w_mis = v[30:0];
      REG_SMOOTH_WEIGHT: w_smo = v[30:0];
      REG_TURN_WEIGHT: w_turn = v[30:0];
      default: w_al = v[30:0];
    endcase
  endfunction

  // Update the running score; an end item queues the expected costs
  function automatic void score_item(item_t it);
    longint r, v0, v1, v2;
    logic [47:0] j_goal, j_eff, j_al, ci, cg, ce, tot, nrm;
    cost_t c;
    v0 = it.vec_x; v1 = it.vec_y; v2 = it.vec_z;
    if (!it.op) begin
      if (n_pts >= MAX_POINTS) return;
      if (it.alert_limit <= 0) begin
        breached = 1;
      end else begin
        r = (longint'(it.protection_level) * 65536) / longint'(it.alert_limit);
        if (r >= 65536) begin
          breached = 1;
          hinge_acc = sat48(hinge_acc + hinge_sq(r - 65536));
        end else if (r > 52429) begin
          hinge_acc = sat48(hinge_acc + hinge_sq(r - 52429));
        end
      end
      if (n_pts >= 1) begin
        turn_acc = sat48(turn_acc + angle_mag(longint'(it.heading) - longint'(last_hd)));
        effort_acc = sat48(effort_acc + vec_norm(v0 - last_v[0], v1 - last_v[1],
                                                 v2 - last_v[2]));
      end
      if (it.future_valid) begin
        nrm = vec_norm(v0 - it.future_vel_x, v1 - it.future_vel_y, v2 - it.future_vel_z);
        nrm = sat48(nrm + (angle_mag(longint'(it.heading) - longint'(it.future_heading)) >> 1));
        align_acc = sat48(align_acc + nrm);
        n_match++;
      end
      last_hd = it.heading;
      last_v[0] = v0; last_v[1] = v1; last_v[2] = v2;
      n_pts++;
      return;
    end
    j_goal = n_pts ? vec_norm(v0 - goal_p[0], v1 - goal_p[1], v2 - goal_p[2]) : '0;
    j_eff = (n_pts >= 2) ? effort_acc / (n_pts - 1) : '0;
    j_al = n_match ? align_acc / n_match : '0;
    ci = weigh(w_int, hinge_acc);
    cg = weigh(w_mis, j_goal);
    ce = weigh(w_smo, j_eff);
    tot = sat48(sat48(ci + cg) + ce);
    tot = sat48(tot + weigh(w_turn, turn_acc));
    tot = sat48(tot + weigh(w_al, j_al));
    if (breached) tot = sat48(tot + INFEASIBLE_PENALTY);
    c.total = tot; c.integ = ci; c.goal = cg; c.effort = ce; c.infeasible = breached;
    cost_q.push_back(c);
    clear_acc();
  endfunction

  task automatic report(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // Input side: track transfers and drive the next item
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      score_item(item_q.pop_front());
      took = 1;
    end
  end

  always @(negedge clk) begin
    if (!in_tvalid || took) begin
      took = 0;
      if (rst_n && item_q.size() > 0 &&
          !((idle_mode == 1 && $urandom_range(99) < 69) ||
            (idle_mode == 3 && $urandom_range(99) < 20))) begin
        in_tvalid <= 1'b1;
        in_tdata <= {2'b0, item_q[0].future_vel_z, item_q[0].future_vel_y,
                     item_q[0].future_vel_x, item_q[0].future_heading, item_q[0].vec_z,
                     item_q[0].vec_y, item_q[0].vec_x, item_q[0].heading,
                     item_q[0].alert_limit, item_q[0].protection_level};
        in_tuser <= {item_q[0].future_valid, item_q[0].op};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side: check each transfer, stall at random
  always @(posedge clk) begin
    cost_t c;
    if (rst_n && out_tvalid && out_tready) begin
      if (cost_q.size() == 0) begin
        report("unexpected result", out_tdata[47:0], '0);
      end else begin
        c = cost_q.pop_front();
        if (out_tdata[47:0] !== c.total) report("total_cost", out_tdata[47:0], c.total);
        if (out_tdata[95:48] !== c.integ) report("integrity_cost", out_tdata[95:48], c.integ);
        if (out_tdata[143:96] !== c.goal) report("goal_cost", out_tdata[143:96], c.goal);
        if (out_tdata[191:144] !== c.effort)
          report("effort_cost", out_tdata[191:144], c.effort);
        if (out_tuser[0] !== c.infeasible)
          report("infeasible", {47'b0, out_tuser[0]}, {47'b0, c.infeasible});
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= !((idle_mode == 2 && $urandom_range(99) < 69) ||
                    (idle_mode == 3 && $urandom_range(99) < 20));
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t mk(logic op, logic [31:0] pl, logic [31:0] al, logic [18:0] hd,
                               logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                               logic fv, logic [18:0] fh, logic [31:0] fx,
                               logic [31:0] fy, logic [31:0] fz);
    item_t it;
    it.op = op; it.protection_level = pl; it.alert_limit = al; it.heading = hd;
    it.vec_x = vx; it.vec_y = vy; it.vec_z = vz; it.future_valid = fv;
    it.future_heading = fh; it.future_vel_x = fx; it.future_vel_y = fy;
    it.future_vel_z = fz;
    return it;
  endfunction

  function automatic logic [31:0] rand_vec();
    if ($urandom_range(99) < 80) return $urandom_range(2097152) - 1048576;
    return $urandom;
  endfunction

  function automatic logic [18:0] rand_hd();
    if ($urandom_range(99) < 85) return $urandom_range(411774) - 205887;
    return $urandom;
  endfunction

  function automatic item_t rand_waypoint();
    item_t it;
    longint al;
    it = mk(1'b0, $urandom, $urandom, rand_hd(), rand_vec(), rand_vec(), rand_vec(),
            $urandom_range(1), rand_hd(), rand_vec(), rand_vec(), rand_vec());
    case ($urandom_range(9))
      0: it.alert_limit = ($urandom_range(1)) ? 32'd0 : (32'h8000_0000 | $urandom);
      1, 2: ;
      default: it.alert_limit = $urandom_range(1 << 20, 1 << 10);
    endcase
    al = it.alert_limit;
    if ($urandom_range(99) < 75 && al > 0)
      it.protection_level = (al * $urandom_range(85000)) >>> 16;
    return it;
  endfunction

  function automatic void push_trajectory(int len);
    for (int k = 0; k < len; k++) item_q.push_back(rand_waypoint());
    item_q.push_back(mk(1'b1, $urandom, $urandom, $urandom, rand_vec(), rand_vec(), rand_vec(),
                        $urandom_range(1), $urandom, $urandom, $urandom, $urandom));
  endfunction

  task automatic write_regs(logic [31:0] vals[8]);
    reg_idx_t idx;
    for (int k = 0; k < 8; k++) begin
      idx = reg_idx_t'(k);
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= idx;
      cfg_wdata <= vals[k];
      @(posedge clk);
      apply_reg(idx, vals[k]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (item_q.size() == 0 && !in_tvalid && cost_q.size() == 0);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  initial begin
    logic [31:0] vals[8];
    int pushed;
    int len;
    goal_p[0] = 0; goal_p[1] = 0; goal_p[2] = 0;
    w_int = 31'd65536; w_mis = 31'd65536; w_smo = 31'd65536; w_turn = 31'd65536;
    w_al = '0;
    clear_acc();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: defaults after reset, edge cases of the scorer
    item_q.push_back(mk(1, 0, 0, 0, 5, 6, 7, 1, 0, 0, 0, 0));      // end with no waypoints
    item_q.push_back(mk(0, 1, 0, 205887, 100, 200, 300, 0, 7, 9, 9, 9)); // zero limit
    item_q.push_back(mk(0, 32'h7FFF_FFFF, 32'h8000_0000, 19'h3FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 19'h40000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000));              // negative limit
    item_q.push_back(mk(0, 32'h7FFF_FFFF, 1, 19'h40000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 1, 19'h3FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF));                             // saturating hinge
    item_q.push_back(mk(1, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        0, 0, 0, 0, 0));
    item_q.push_back(mk(0, 65536, 65536, -205887, 0, 0, 0, 1, 205887, 10, 0, 0));
    item_q.push_back(mk(0, 60000, 65536, 205887, 65536, 0, 0, 1, -205887, 0, 0, 0));
    item_q.push_back(mk(0, 52429, 65536, 0, 0, 65536, 0, 0, 19'h2AAAA, 32'hDEAD_BEEF,
                        32'h1234_5678, 32'hFFFF_FFFF));              // no future sample
    item_q.push_back(mk(0, -1000, 65536, 1000, 0, 0, 65536, 1, 1000, 0, 0, 65536));
    item_q.push_back(mk(1, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        1, 0, 0, 0, 0));
    item_q.push_back(mk(0, 1, 65536, 0, 1, 1, 1, 0, 0, 0, 0, 0));   // single waypoint
    item_q.push_back(mk(1, 0, 0, 0, 3, 4, 0, 0, 0, 0, 0, 0));
    drain();

    // Random phases, each with its own register setting and idling mode
    for (int ph = 0; ph < 8; ph++) begin
      for (int k = 0; k < 8; k++) vals[k] = (k < 3) ? rand_vec() : $urandom_range(262144);
      if (ph == 1) begin
        vals = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      end else if (ph == 2) begin
        vals = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0};
      end else if (ph == 5) begin
        for (int k = 0; k < 8; k++) vals[k] = $urandom;
      end
      write_regs(vals);
      idle_mode = ph % 4;
      pushed = 0;
      while (pushed < 180) begin
        case ($urandom_range(99)) inside
          [0:4]: len = 0;
          [5:84]: len = $urandom_range(10, 1);
          [85:95]: len = $urandom_range(30, 11);
          default: len = $urandom_range(70, 62);
        endcase
        push_trajectory(len);
        pushed += len + 1;
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
